/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the calendar date converter.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

/* src/sctd_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Calendar date converter package
// Shared widths, constants, the queue entry type and calendar functions.
// ---------------------------------------------------------------------------
package sctd_pkg;

    localparam int unsigned EPOCH_W         = 32;
    localparam int unsigned YEAR_W          = 12;
    localparam int unsigned DAY_W           = 16;
    localparam int unsigned SOD_W           = 17;
    localparam int unsigned SECS_PER_DAY    = 86400;
    localparam int unsigned SECS_PER_HOUR   = 3600;
    localparam int unsigned SECS_PER_MIN    = 60;
    localparam int unsigned QUEUE_DEPTH     = 2;
    localparam logic [YEAR_W-1:0] BASE_YEAR_RESET = 12'd1970;

    // A day is 675 times 128 seconds. The reciprocal of 675 scaled by 2^35 gives the
    // exact quotient for every 25-bit count left after dropping the low seven bits.
    localparam int unsigned DAY_SHIFT       = 7;
    localparam int unsigned DAY_ODD         = 675;
    localparam int unsigned DAY_RECIP       = 50903317;
    localparam int unsigned DAY_RECIP_W     = 26;
    localparam int unsigned DAY_RECIP_SHIFT = 35;

    typedef struct packed {
        logic [DAY_W-1:0] days;
        logic [SOD_W-1:0] sod;
    } job_t;

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-1:0] m;
        logic              m400_zero;
        logic              m100_zero;
        m = y;
        if (m >= 12'd3200) m = m - 12'd3200;
        if (m >= 12'd1600) m = m - 12'd1600;
        if (m >= 12'd800)  m = m - 12'd800;
        if (m >= 12'd400)  m = m - 12'd400;
        m400_zero = (m == '0);
        if (m >= 12'd200)  m = m - 12'd200;
        if (m >= 12'd100)  m = m - 12'd100;
        m100_zero = (m == '0);
        return (y[1:0] == 2'b00) && (m400_zero || !m100_zero);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        unique case (month)
            4'd2:                         len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:      len = 5'd30;
            default:                      len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

/* src/sctd_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Calendar date converter front end
// Accepts a seconds beat and splits it into whole days and second of day
// with a reciprocal multiply and a multiply-back, then queues the job.
// ---------------------------------------------------------------------------
module sctd_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sctd_pkg::EPOCH_W-1:0]  s_epoch_seconds,
    output logic                          push_valid,
    input  logic                          push_ready,
    output sctd_pkg::job_t                push_job
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MUL  = 2'd1;
    localparam logic [1:0] F_REM  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    localparam int unsigned EPOCH_W  = sctd_pkg::EPOCH_W;
    localparam int unsigned DAY_W    = sctd_pkg::DAY_W;
    localparam int unsigned SOD_W    = sctd_pkg::SOD_W;
    localparam int unsigned SHIFT    = sctd_pkg::DAY_SHIFT;
    localparam int unsigned SCALED_W = EPOCH_W - SHIFT;
    localparam int unsigned RECIP_W  = sctd_pkg::DAY_RECIP_W;
    localparam int unsigned PROD_W   = SCALED_W + RECIP_W;
    localparam int unsigned REM_W    = SOD_W - SHIFT;

    localparam logic [RECIP_W-1:0]  RECIP_C = RECIP_W'(sctd_pkg::DAY_RECIP);
    localparam logic [SCALED_W-1:0] ODD_C   = SCALED_W'(sctd_pkg::DAY_ODD);

    logic [1:0]          state_reg, state_next;
    logic [SCALED_W-1:0] scaled_reg, scaled_next;
    logic [SHIFT-1:0]    low_reg, low_next;
    logic [DAY_W-1:0]    days_reg, days_next;
    logic [SOD_W-1:0]    sod_reg, sod_next;
    logic [PROD_W-1:0]   product;
    logic [SCALED_W-1:0] remainder;

    assign product   = PROD_W'(scaled_reg) * PROD_W'(RECIP_C);
    assign remainder = scaled_reg - SCALED_W'(days_reg) * ODD_C;

    assign s_ready       = (state_reg == F_IDLE);
    assign push_valid    = (state_reg == F_PUSH);
    assign push_job.days = days_reg;
    assign push_job.sod  = sod_reg;

    always_comb begin
        state_next  = state_reg;
        scaled_next = scaled_reg;
        low_next    = low_reg;
        days_next   = days_reg;
        sod_next    = sod_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (s_valid) begin
                    scaled_next = s_epoch_seconds[EPOCH_W-1:SHIFT];
                    low_next    = s_epoch_seconds[SHIFT-1:0];
                    state_next  = F_MUL;
                end
            end
            F_MUL: begin
                days_next  = product[sctd_pkg::DAY_RECIP_SHIFT +: DAY_W];
                state_next = F_REM;
            end
            F_REM: begin
                sod_next   = {remainder[REM_W-1:0], low_reg};
                state_next = F_PUSH;
            end
            F_PUSH: begin
                if (push_ready) begin
                    state_next = F_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        scaled_reg <= scaled_next;
        low_reg    <= low_next;
        days_reg   <= days_next;
        sod_reg    <= sod_next;
    end

endmodule

/* src/sctd_fifo.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Calendar date converter job queue
// Short first-in first-out queue of day and second-of-day jobs.
// ---------------------------------------------------------------------------
module sctd_fifo #(
    parameter int unsigned DEPTH = sctd_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  sctd_pkg::job_t push_job,
    output logic           pop_valid,
    input  logic           pop_ready,
    output sctd_pkg::job_t pop_job
);

    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    sctd_pkg::job_t    entry_reg [DEPTH];
    logic [IDX_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* src/sctd_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Calendar date converter back end
// Walks years and months from the base year, splits the second of day into
// hours, minutes and seconds, and holds the result beat for the output.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sctd_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [sctd_pkg::YEAR_W-1:0]  base_year,
    input  logic                         pop_valid,
    output logic                         pop_ready,
    input  sctd_pkg::job_t               pop_job,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [5:0]                   m_second_of_minute,
    output logic [5:0]                   m_minute_of_hour,
    output logic [4:0]                   m_hour_of_day,
    output logic [4:0]                   m_day_of_month,
    output logic [3:0]                   m_month_of_year,
    output logic [sctd_pkg::YEAR_W-1:0]  m_calendar_year
);

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_YEAR  = 3'd1;
    localparam logic [2:0] B_MONTH = 3'd2;
    localparam logic [2:0] B_HOUR  = 3'd3;
    localparam logic [2:0] B_MIN   = 3'd4;
    localparam logic [2:0] B_DONE  = 3'd5;

    localparam int unsigned YEAR_W = sctd_pkg::YEAR_W;
    localparam int unsigned DAY_W  = sctd_pkg::DAY_W;
    localparam int unsigned SOD_W  = sctd_pkg::SOD_W;

    logic [2:0]        state_reg, state_next;
    logic              m_valid_reg, m_valid_next;
    logic [DAY_W-1:0]  day_reg, day_next;
    logic [YEAR_W-1:0] year_reg, year_next;
    logic [3:0]        month_reg, month_next;
    logic [SOD_W-1:0]  sod_reg, sod_next;
    logic [4:0]        hour_reg, hour_next;
    logic [5:0]        minute_reg, minute_next;
    logic [5:0]        o_sec_reg, o_sec_next;
    logic [5:0]        o_min_reg, o_min_next;
    logic [4:0]        o_hour_reg, o_hour_next;
    logic [4:0]        o_day_reg, o_day_next;
    logic [3:0]        o_month_reg, o_month_next;
    logic [YEAR_W-1:0] o_year_reg, o_year_next;

    logic              leap;
    logic [8:0]        year_len;
    logic [4:0]        mon_len;
    logic              out_free;

    assign leap     = sctd_pkg::is_leap(year_reg);
    assign year_len = leap ? 9'd366 : 9'd365;
    assign mon_len  = sctd_pkg::month_len(month_reg, leap);
    assign out_free = !m_valid_reg || m_ready;

    assign pop_ready          = (state_reg == B_IDLE);
    assign m_valid            = m_valid_reg;
    assign m_second_of_minute = o_sec_reg;
    assign m_minute_of_hour   = o_min_reg;
    assign m_hour_of_day      = o_hour_reg;
    assign m_day_of_month     = o_day_reg;
    assign m_month_of_year    = o_month_reg;
    assign m_calendar_year    = o_year_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        day_next     = day_reg;
        year_next    = year_reg;
        month_next   = month_reg;
        sod_next     = sod_reg;
        hour_next    = hour_reg;
        minute_next  = minute_reg;
        o_sec_next   = o_sec_reg;
        o_min_next   = o_min_reg;
        o_hour_next  = o_hour_reg;
        o_day_next   = o_day_reg;
        o_month_next = o_month_reg;
        o_year_next  = o_year_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (pop_valid) begin
                    day_next    = pop_job.days + 1'b1;
                    year_next   = base_year;
                    month_next  = 4'd1;
                    sod_next    = pop_job.sod;
                    hour_next   = '0;
                    minute_next = '0;
                    state_next  = B_YEAR;
                end
            end
            B_YEAR: begin
                if (day_reg <= DAY_W'(year_len)) begin
                    state_next = B_MONTH;
                end else begin
                    day_next  = day_reg - DAY_W'(year_len);
                    year_next = year_reg + 1'b1;
                end
            end
            B_MONTH: begin
                if ((month_reg >= 4'd12) || (day_reg <= DAY_W'(mon_len))) begin
                    state_next = B_HOUR;
                end else begin
                    day_next   = day_reg - DAY_W'(mon_len);
                    month_next = month_reg + 1'b1;
                end
            end
            B_HOUR: begin
                if (sod_reg >= SOD_W'(sctd_pkg::SECS_PER_HOUR)) begin
                    sod_next  = sod_reg - SOD_W'(sctd_pkg::SECS_PER_HOUR);
                    hour_next = hour_reg + 1'b1;
                end else begin
                    state_next = B_MIN;
                end
            end
            B_MIN: begin
                if (sod_reg >= SOD_W'(sctd_pkg::SECS_PER_MIN)) begin
                    sod_next    = sod_reg - SOD_W'(sctd_pkg::SECS_PER_MIN);
                    minute_next = minute_reg + 1'b1;
                end else begin
                    state_next = B_DONE;
                end
            end
            B_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    o_sec_next   = sod_reg[5:0];
                    o_min_next   = minute_reg;
                    o_hour_next  = hour_reg;
                    o_day_next   = day_reg[4:0];
                    o_month_next = month_reg;
                    o_year_next  = year_reg;
                    state_next   = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        day_reg     <= day_next;
        year_reg    <= year_next;
        month_reg   <= month_next;
        sod_reg     <= sod_next;
        hour_reg    <= hour_next;
        minute_reg  <= minute_next;
        o_sec_reg   <= o_sec_next;
        o_min_reg   <= o_min_next;
        o_hour_reg  <= o_hour_next;
        o_day_reg   <= o_day_next;
        o_month_reg <= o_month_next;
        o_year_reg  <= o_year_next;
    end

    `ASSERT_NEXT(a_done_loads_output, aclk, aresetn, (state_reg == B_DONE) && out_free, m_valid_reg && (state_reg == B_IDLE))
    `ASSERT_IMPLIES(a_month_in_range, aclk, aresetn, state_reg == B_HOUR, (month_reg >= 4'd1) && (month_reg <= 4'd12))
    `ASSERT_IMPLIES(a_time_split_done, aclk, aresetn, state_reg == B_DONE, (sod_reg < 17'd60) && (minute_reg < 6'd60) && (hour_reg < 5'd24))
    `ASSERT_NEXT(a_stall_holds_year, aclk, aresetn, m_valid_reg && !m_ready, $stable(o_year_reg) && m_valid_reg)

endmodule

/* src/seconds_to_calendar_date_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Seconds to calendar date converter
// Turns a 32-bit seconds count since January 1 of a base year into the
// Gregorian date and the time of day, one result beat per input beat.
// ---------------------------------------------------------------------------
// The front end splits each input count into whole days and second of day
// with a reciprocal multiply and a multiply-back, then pushes the job into a
// queue, two entries deep by default, and takes no new beat until the queue
// has accepted the job. The back end walks the years from the base year, then
// the months, then the whole hours and whole minutes, and these walks set the
// sustained rate. The base year register is written through the cfg port at
// any time, and is sampled when the back end picks up a job from the queue.
module seconds_to_calendar_date_core #(
    parameter int unsigned QUEUE_DEPTH = sctd_pkg::QUEUE_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sctd_pkg::YEAR_W-1:0]   cfg_base_year,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sctd_pkg::EPOCH_W-1:0]  s_epoch_seconds,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [5:0]                    m_second_of_minute,
    output logic [5:0]                    m_minute_of_hour,
    output logic [4:0]                    m_hour_of_day,
    output logic [4:0]                    m_day_of_month,
    output logic [3:0]                    m_month_of_year,
    output logic [sctd_pkg::YEAR_W-1:0]   m_calendar_year
);

    logic [sctd_pkg::YEAR_W-1:0] base_year_reg;
    logic                        push_valid;
    logic                        push_ready;
    sctd_pkg::job_t              push_job;
    logic                        pop_valid;
    logic                        pop_ready;
    sctd_pkg::job_t              pop_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_year_reg <= sctd_pkg::BASE_YEAR_RESET;
        end else if (cfg_valid) begin
            base_year_reg <= cfg_base_year;
        end
    end

    sctd_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_epoch_seconds (s_epoch_seconds),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_job        (push_job)
    );

    sctd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    sctd_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .base_year          (base_year_reg),
        .pop_valid          (pop_valid),
        .pop_ready          (pop_ready),
        .pop_job            (pop_job),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_second_of_minute (m_second_of_minute),
        .m_minute_of_hour   (m_minute_of_hour),
        .m_hour_of_day      (m_hour_of_day),
        .m_day_of_month     (m_day_of_month),
        .m_month_of_year    (m_month_of_year),
        .m_calendar_year    (m_calendar_year)
    );

endmodule
